[sv/sine_beep_generator_defines.svh]
// ----------------------------------------------------------------------------
// Sine beep generator assertion macros
// Shared property wrappers for the concurrent checks of the beep generator.
// ----------------------------------------------------------------------------
`ifndef SINE_BEEP_GENERATOR_DEFINES_SVH
`define SINE_BEEP_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SBG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sbg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine beep generator package
// Types, register map, reset values and sine polynomial coefficients.
// ----------------------------------------------------------------------------
package sbg_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF      = 24;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 16;
  localparam int APB_AW     = 5;

  // Register map, one 32-bit word per register
  typedef enum logic [2:0] {
    REG_PHASE_INC = 3'd0,
    REG_BEEP_SAMP = 3'd1,
    REG_GAP_SAMP  = 3'd2,
    REG_BEEP_CNT  = 3'd3,
    REG_AMPLITUDE = 3'd4
  } sbg_reg_t;

  typedef struct packed {
    logic [31:0] phase_increment;
    logic [23:0] beep_samples;
    logic [23:0] gap_samples;
    logic [7:0]  beep_count;
    logic [14:0] amplitude;
  } sbg_cfg_t;

  localparam sbg_cfg_t CFG_RESET = '{
    phase_increment: 32'd178956971,
    beep_samples:    24'd2400,
    gap_samples:     24'd2400,
    beep_count:      8'd3,
    amplitude:       15'd12000
  };

  typedef struct packed {
    logic in_tone;
    logic busy_res;
    logic last;
  } sbg_flags_t;

  typedef struct packed {
    logic [31:0] phase;
    sbg_flags_t  flags;
  } sbg_cmd_t;

  typedef struct packed {
    logic signed [15:0] sample;
    sbg_flags_t         flags;
  } sbg_res_t;

  // Q30 odd polynomial for sin(u*pi/2), u in [0,1]
  localparam logic [30:0] SIN_A   = 31'd1686629713;
  localparam logic [29:0] SIN_B   = 30'd693598671;
  localparam logic [26:0] SIN_C   = 27'd85569278;
  localparam logic [22:0] SIN_D   = 23'd4858496;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

endpackage

[sv/sine_beep_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine beep generator
// Beep-sequence tone source: one audio sample per input transaction.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                       Payload
// -------   -----------------------------   ------------------------------------
// input     push / full                     start_req
// result    pop / empty                     sample, in_tone, busy_res, last
// config    psel, penable, pwrite / pready  paddr, pwdata, prdata
//
// One transaction per cycle while the command queue is not full; the sequencer
// updates its segment state once per accepted slot, which sets the rate.
// A result passes through the command queue write, issue, and the six stages of
// the sine pipeline on its way into the output queue.
// Reset is synchronous and returns registers to defaults and the block to idle.
// A full output queue stops issue from the command queue; a full command queue
// raises full, so a stall on the output side reaches the input side as well.
//
module sine_beep_generator import sbg_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int COUNT_BITS      = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // sample slots in
  input  logic               push,
  input  logic               start_req,
  output logic               full,
  // samples out
  input  logic               pop,
  output logic               empty,
  output logic signed [15:0] sample,
  output logic               in_tone,
  output logic               busy_res,
  output logic               last
);

`include "sine_beep_generator_defines.svh"

  localparam int RW = $clog2(OUTQ_DEPTH) + 1;

  sbg_cfg_t    cfg;
  sbg_reg_t    reg_sel;
  logic        cfg_wr;

  logic        in_acc;
  sbg_cmd_t    cmd;
  sbg_cmd_t    cmdq_rdata;
  logic        cmdq_empty;
  logic        issue;

  logic        pipe_valid;
  sbg_res_t    pipe_res;
  sbg_res_t    outq_rdata;
  logic        outq_full;
  logic        out_pop;

  logic [RW-1:0] resv;
  logic [RW-1:0] resv_next;

  // --------------------------------------------------------------------------
  // Configuration registers; pready tied high, so every access completes in
  // its access phase.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = sbg_reg_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PHASE_INC: cfg.phase_increment <= pwdata;
        REG_BEEP_SAMP: cfg.beep_samples    <= pwdata[23:0];
        REG_GAP_SAMP:  cfg.gap_samples     <= pwdata[23:0];
        REG_BEEP_CNT:  cfg.beep_count      <= pwdata[7:0];
        REG_AMPLITUDE: cfg.amplitude       <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PHASE_INC: prdata = cfg.phase_increment;
      REG_BEEP_SAMP: prdata = 32'(cfg.beep_samples);
      REG_GAP_SAMP:  prdata = 32'(cfg.gap_samples);
      REG_BEEP_CNT:  prdata = 32'(cfg.beep_count);
      REG_AMPLITUDE: prdata = 32'(cfg.amplitude);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front: classify each slot as tone, gap or idle and record the phase.
  // --------------------------------------------------------------------------
  assign in_acc = push && !full;

  sbg_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_acc),
    .start_req (start_req),
    .cfg       (cfg),
    .cmd       (cmd)
  );

  // Decouple the sequencer from the sine pipeline.
  sbg_fifo #(
    .WIDTH ($bits(sbg_cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (in_acc),
    .wdata (cmd),
    .pop   (issue),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty),
    .full  (full)
  );

  // --------------------------------------------------------------------------
  // Back: issue only with a free output queue slot reserved, so the pipeline
  // never has to stall.
  // --------------------------------------------------------------------------
  assign out_pop   = pop && !empty;
  assign issue     = !cmdq_empty && (resv < RW'(OUTQ_DEPTH));
  assign resv_next = resv + RW'(issue) - RW'(out_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      resv <= '0;
    end else begin
      resv <= resv_next;
    end
  end

  sbg_sine #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .in_cmd    (cmdq_rdata),
    .amplitude (cfg.amplitude),
    .out_valid (pipe_valid),
    .out_res   (pipe_res)
  );

  sbg_fifo #(
    .WIDTH ($bits(sbg_res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (pipe_valid),
    .wdata (pipe_res),
    .pop   (pop),
    .rdata (outq_rdata),
    .empty (empty),
    .full  (outq_full)
  );

  assign sample   = outq_rdata.sample;
  assign in_tone  = outq_rdata.flags.in_tone;
  assign busy_res = outq_rdata.flags.busy_res;
  assign last     = outq_rdata.flags.last;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SBG_ASSERT_IMP(a_resv_bound, clk, rst, 1'b1, resv <= RW'(OUTQ_DEPTH), "reservation count above output queue depth")
  `SBG_ASSERT_IMP(a_no_overflow, clk, rst, pipe_valid, !outq_full, "pipeline wrote into a full output queue")
  `SBG_ASSERT_IMP(a_idle_empty, clk, rst, resv == '0, empty, "output queue holds data with nothing reserved")
  `SBG_ASSERT_IMP(a_flags, clk, rst, in_acc, (!cmd.flags.in_tone && !cmd.flags.last) || cmd.flags.busy_res, "tone or last flagged outside a sequence")
  `SBG_ASSERT_NXT(a_resv_track, clk, rst, issue && !out_pop, resv == $past(resv) + RW'(1), "reservation count missed an issue")

endmodule

[sv/sbg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine beep generator FIFO
// Small show-ahead queue built from a register file.
// ----------------------------------------------------------------------------
module sbg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(do_push);
      rd_ptr <= rd_ptr + AW'(do_pop);
      count  <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (AW+1)'(DEPTH));

endmodule

[sv/sbg_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine beep generator sequencer
// Tracks beep and gap segments, one sample slot per accepted transaction.
// ----------------------------------------------------------------------------
module sbg_seq import sbg_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic     start_req,
  input  sbg_cfg_t cfg,
  output sbg_cmd_t cmd
);

  localparam int LW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_BITS{1'b1}});

  function automatic logic [COUNT_BITS-1:0] clamp_len(input logic [23:0] len);
    logic [LW-1:0] ext;
    ext = LW'(len);
    return COUNT_BITS'((ext > CNT_MAX) ? CNT_MAX : ext);
  endfunction

  logic [31:0]           phase_acc;
  logic [COUNT_BITS-1:0] seg_cnt;
  logic [7:0]            beeps_done;
  logic                  in_gap;
  logic                  running;

  logic [31:0]           phase_next;
  logic [COUNT_BITS-1:0] seg_cnt_next;
  logic [7:0]            beeps_done_next;
  logic                  in_gap_next;
  logic                  running_next;

  logic [31:0]           a_phase;
  logic [COUNT_BITS-1:0] a_cnt;
  logic [7:0]            a_bd;
  logic                  a_gap;
  logic                  a_run;
  logic [8:0]            bd_inc;
  logic                  done_all;
  logic [COUNT_BITS-1:0] seg_len;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  beep_zero;
  logic                  gap_zero;

  assign beep_zero = (cfg.beep_samples == '0);
  assign gap_zero  = (cfg.gap_samples == '0);

  always_comb begin
    // start: restart from the first beep, skip an empty first beep
    a_phase = phase_acc;
    a_cnt   = seg_cnt;
    a_bd    = beeps_done;
    a_gap   = in_gap;
    a_run   = running;
    if (start_req) begin
      a_phase = '0;
      a_cnt   = '0;
      a_bd    = '0;
      a_gap   = 1'b0;
      a_run   = (cfg.beep_count != '0);
      if (a_run && beep_zero) begin
        if (gap_zero || (cfg.beep_count <= 8'd1)) begin
          a_run = 1'b0;
        end else begin
          a_gap = 1'b1;
          a_bd  = 8'd1;
        end
      end
    end

    bd_inc   = {1'b0, a_bd} + 9'd1;
    done_all = (bd_inc >= {1'b0, cfg.beep_count});
    seg_len  = a_gap ? clamp_len(cfg.gap_samples) : clamp_len(cfg.beep_samples);
    cnt_inc  = a_cnt + COUNT_BITS'(1);

    phase_next      = a_phase;
    seg_cnt_next    = a_cnt;
    beeps_done_next = a_bd;
    in_gap_next     = a_gap;
    running_next    = a_run;

    cmd.phase          = a_phase;
    cmd.flags.busy_res = a_run;
    cmd.flags.in_tone  = a_run && !a_gap;
    cmd.flags.last     = 1'b0;

    if (a_run) begin
      if (!a_gap) begin
        phase_next = a_phase + cfg.phase_increment;
      end
      seg_cnt_next = cnt_inc;
      if (cnt_inc >= seg_len) begin
        seg_cnt_next = '0;
        if (!a_gap) begin
          // end of a beep
          if (done_all) begin
            running_next = 1'b0;
          end else begin
            beeps_done_next = bd_inc[7:0];
            if (!gap_zero) begin
              in_gap_next = 1'b1;
            end else if (beep_zero) begin
              running_next = 1'b0;
            end else begin
              phase_next = '0;
            end
          end
        end else begin
          // end of a gap: next beep starts at phase zero
          in_gap_next = 1'b0;
          phase_next  = '0;
          if (beep_zero) begin
            if (gap_zero || done_all) begin
              running_next = 1'b0;
            end else begin
              in_gap_next     = 1'b1;
              beeps_done_next = bd_inc[7:0];
            end
          end
        end
        cmd.flags.last = !running_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      seg_cnt    <= '0;
      beeps_done <= '0;
      in_gap     <= 1'b0;
      running    <= 1'b0;
    end else if (accept) begin
      phase_acc  <= phase_next;
      seg_cnt    <= seg_cnt_next;
      beeps_done <= beeps_done_next;
      in_gap     <= in_gap_next;
      running    <= running_next;
    end
  end

endmodule

[sv/sbg_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine beep generator sine pipeline
// Six-stage fixed-point sine and amplitude scaling, one sample per cycle.
// ----------------------------------------------------------------------------
module sbg_sine import sbg_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  sbg_cmd_t    in_cmd,
  input  logic [14:0] amplitude,
  output logic        out_valid,
  output sbg_res_t    out_res
);

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int SH = 30 - 2 * QB;
  localparam logic [QB:0] QSIZE = (QB+1)'(1) << QB;

  logic [1:0]    quad;
  logic [QB-1:0] q;
  logic [QB:0]   m;
  logic [2*QB+1:0] mm;
  logic [31:0]   u2_wide;

  logic [5:0]    v;

  logic [QB:0]   m1, m2, m3, m4;
  logic [30:0]   u2_1, u2_2, u2_3;
  logic          neg1, neg2, neg3, neg4, neg5;
  sbg_flags_t    f1, f2, f3, f4, f5;
  logic [26:0]   t1_2;
  logic [29:0]   t2_3;
  logic [30:0]   t3_4;
  logic [30:0]   s_5;

  logic [53:0]      p1;
  logic [57:0]      p2;
  logic [60:0]      p3;
  logic [QB+31:0]   p4;
  logic [31:0]      s_raw;
  logic [45:0]      p5;
  logic [15:0]      mag;

  assign quad    = in_cmd.phase[31:30];
  assign q       = in_cmd.phase[29 -: QB];
  assign m       = quad[0] ? (QSIZE - {1'b0, q}) : {1'b0, q};
  assign mm      = (2*QB+2)'(m) * (2*QB+2)'(m);
  assign u2_wide = {mm, {SH{1'b0}}};

  assign p1    = 54'(u2_1) * 54'(SIN_D);
  assign p2    = 58'(u2_2) * 58'(t1_2);
  assign p3    = 61'(u2_3) * 61'(t2_3);
  assign p4    = (QB+32)'(m4) * (QB+32)'(t3_4);
  assign s_raw = p4[QB+31:QB];
  assign p5    = 46'(amplitude) * 46'(s_5);
  assign mag   = p5[45:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: fold to quarter wave, square
    m1   <= m;
    u2_1 <= u2_wide[30:0];
    neg1 <= quad[1];
    f1   <= in_cmd.flags;
    // stage 2
    t1_2 <= SIN_C - 27'(p1[53:30]);
    u2_2 <= u2_1;
    m2   <= m1;
    neg2 <= neg1;
    f2   <= f1;
    // stage 3
    t2_3 <= SIN_B - 30'(p2[57:30]);
    u2_3 <= u2_2;
    m3   <= m2;
    neg3 <= neg2;
    f3   <= f2;
    // stage 4
    t3_4 <= SIN_A - p3[60:30];
    m4   <= m3;
    neg4 <= neg3;
    f4   <= f3;
    // stage 5: clamp to one
    s_5  <= (s_raw > 32'(Q30_ONE)) ? Q30_ONE : s_raw[30:0];
    neg5 <= neg4;
    f5   <= f4;
    // stage 6: scale and sign
    out_res.flags <= f5;
    if (!f5.in_tone) begin
      out_res.sample <= '0;
    end else if (neg5) begin
      out_res.sample <= 16'd0 - mag;
    end else begin
      out_res.sample <= mag;
    end
  end

  assign out_valid = v[5];

endmodule

[tb/tb_sine_beep_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine beep generator testbench
// Drives sample slots with start requests into the beep generator, programs
// its registers between phases, and checks every output sample and flag
// against a cycle-free model of the beep sequencer and fixed-point sine.
// ----------------------------------------------------------------------------
module tb_sine_beep_generator;
  import sbg_pkg::*;

  localparam int SINE_BITS      = 10;
  localparam int SEG_BITS       = 24;
  localparam int PIPE_LATENCY   = 7;
  localparam int RANDOM_SLOTS   = 1950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_PRINTS     = 40;

  // Q30 polynomial coefficients for sin(u*pi/2)
  localparam logic [63:0] COEF_A = 64'd1686629713;
  localparam logic [63:0] COEF_B = 64'd693598671;
  localparam logic [63:0] COEF_C = 64'd85569278;
  localparam logic [63:0] COEF_D = 64'd4858496;
  localparam logic [63:0] Q30    = 64'd1073741824;

  typedef struct {
    logic signed [15:0] sample;
    logic               in_tone;
    logic               busy_res;
    logic               last;
  } tone_slot_t;

  // DUT signals; the inputs are all known from time zero
  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [APB_AW-1:0]  paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               push      = 1'b0;
  logic               start_req = 1'b0;
  logic               full;
  logic               pop       = 1'b0;
  logic               empty;
  logic signed [15:0] sample;
  logic               in_tone;
  logic               busy_res;
  logic               last;

  // Register copy as the sequencer model sees it
  logic [31:0] cfg_inc;
  logic [23:0] cfg_beep;
  logic [23:0] cfg_gap;
  logic [7:0]  cfg_count;
  logic [14:0] cfg_amp;

  // Sequencer model state
  logic [31:0]         tone_phase;
  logic [SEG_BITS-1:0] seg_cnt;
  logic [7:0]          beeps_done;
  logic                in_gap;
  logic                running;

  logic       pending_starts[$];
  tone_slot_t expected_samples[$];

  int err_cnt     = 0;
  int slots_sent  = 0;
  int slots_seen  = 0;
  int tone_seen   = 0;
  int ends_seen   = 0;
  int full_cycles = 0;
  int phase_cnt   = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  sine_beep_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .start_req(start_req),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .sample   (sample),
    .in_tone  (in_tone),
    .busy_res (busy_res),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sequencer and sine model
  // --------------------------------------------------------------------------

  // Signed sample for one phase: quadrant from the top two index bits,
  // mirrored quarter-wave position as Q30, odd polynomial, then amplitude.
  function automatic logic [15:0] sine_of(input logic [31:0] ph, input logic [14:0] amp);
    logic [SINE_BITS-1:0] idx;
    logic [1:0]           quad;
    logic [SINE_BITS-3:0] q;
    logic [SINE_BITS-2:0] m;
    logic [63:0]          u, u2, t, s, mag;
    idx  = ph[31 -: SINE_BITS];
    quad = idx[SINE_BITS-1 -: 2];
    q    = idx[SINE_BITS-3:0];
    m    = quad[0] ? ((SINE_BITS-1)'(1 << (SINE_BITS-2)) - q) : {1'b0, q};
    u    = 64'(m) << (30 - (SINE_BITS - 2));
    u2   = (u * u) >> 30;
    t    = COEF_C - ((u2 * COEF_D) >> 30);
    t    = COEF_B - ((u2 * t) >> 30);
    t    = COEF_A - ((u2 * t) >> 30);
    s    = (u * t) >> 30;
    if (s > Q30) s = Q30;
    mag  = (64'(amp) * s) >> 30;
    return quad[1] ? 16'(64'd0 - mag) : mag[15:0];
  endfunction

  function automatic logic [23:0] seg_len();
    return in_gap ? cfg_gap : cfg_beep;
  endfunction

  // Close the finished segment: a beep ends the sequence or opens a gap,
  // a gap opens the next beep with the phase cleared.
  function automatic void close_segment();
    seg_cnt = '0;
    if (!in_gap) begin
      if (int'(beeps_done) + 1 >= int'(cfg_count)) running = 1'b0;
      else in_gap = 1'b1;
      beeps_done = beeps_done + 8'd1;
    end else begin
      in_gap     = 1'b0;
      tone_phase = '0;
    end
  endfunction

  function automatic void skip_empty_segments();
    int guard;
    guard = 0;
    while (running && seg_len() == 0 && guard < 1024) begin
      close_segment();
      guard++;
    end
    if (guard >= 1024) running = 1'b0;
  endfunction

  function automatic tone_slot_t predict_slot(input logic start);
    tone_slot_t r;
    r = '{sample: '0, in_tone: 1'b0, busy_res: 1'b0, last: 1'b0};
    if (start) begin
      tone_phase = '0;
      seg_cnt    = '0;
      beeps_done = '0;
      in_gap     = 1'b0;
      running    = (cfg_count != 0);
      skip_empty_segments();
    end
    if (running) begin
      r.busy_res = 1'b1;
      if (!in_gap) begin
        r.in_tone  = 1'b1;
        r.sample   = sine_of(tone_phase, cfg_amp);
        tone_phase = tone_phase + cfg_inc;
      end
      seg_cnt = seg_cnt + SEG_BITS'(1);
      if (seg_cnt >= seg_len()) begin
        close_segment();
        skip_empty_segments();
        if (!running) r.last = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void reset_model();
    cfg_inc    = 32'd178956971;
    cfg_beep   = 24'd2400;
    cfg_gap    = 24'd2400;
    cfg_count  = 8'd3;
    cfg_amp    = 15'd12000;
    tone_phase = '0;
    seg_cnt    = '0;
    beeps_done = '0;
    in_gap     = 1'b0;
    running    = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued start flags, hold on full, idle at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : slot_driver
    bit steady;
    if (rst) begin
      push      <= 1'b0;
      start_req <= 1'b0;
    end else begin
      steady = (slots_sent >= 800 && slots_sent < 1100);
      if (push && full) full_cycles++;
      if (push && !full) begin
        // Transaction accepted: advance the model by one slot
        expected_samples.push_back(predict_slot(start_req));
        slots_sent++;
      end
      if (push && full) begin
        // hold the offered transaction until there is room
      end else if (pending_starts.size() != 0 && (steady || $urandom_range(99, 0) >= 34)) begin
        push      <= 1'b1;
        start_req <= pending_starts.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take results, compare field by field with the oldest expectation
  // --------------------------------------------------------------------------
  task automatic flag_sample_error(input string what);
    if (err_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  always @(posedge clk) begin : sample_monitor
    tone_slot_t want;
    bit         steady;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      steady = (slots_seen >= 800 && slots_seen < 1100);
      if (pop && !empty) begin
        slots_seen++;
        if (in_tone === 1'b1) tone_seen++;
        if (last === 1'b1) ends_seen++;
        if (expected_samples.size() == 0) begin
          flag_sample_error("result with no slot outstanding");
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want.sample)
            flag_sample_error($sformatf("slot %0d sample %0d, want %0d",
                                        slots_seen, sample, want.sample));
          if (in_tone !== want.in_tone)
            flag_sample_error($sformatf("slot %0d in_tone %b, want %b",
                                        slots_seen, in_tone, want.in_tone));
          if (busy_res !== want.busy_res)
            flag_sample_error($sformatf("slot %0d busy_res %b, want %b",
                                        slots_seen, busy_res, want.busy_res));
          if (last !== want.last)
            flag_sample_error($sformatf("slot %0d last %b, want %b",
                                        slots_seen, last, want.last));
        end
      end
      // Hold off once for a long stretch while a big batch is queued,
      // so both internal queues fill and full rises
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && pending_starts.size() > 40) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      pop <= (hold_left == 0) && (steady || $urandom_range(99, 0) >= 34);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || psel) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Register writes and stimulus phases
  // --------------------------------------------------------------------------

  // Setup cycle, then access cycle; the register takes the value at the
  // edge that closes the access cycle.
  task automatic reg_write(input sbg_reg_t r, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_PHASE_INC: cfg_inc   = val;
      REG_BEEP_SAMP: cfg_beep  = val[23:0];
      REG_GAP_SAMP:  cfg_gap   = val[23:0];
      REG_BEEP_CNT:  cfg_count = val[7:0];
      REG_AMPLITUDE: cfg_amp   = val[14:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] inc, input logic [23:0] beep,
                             input logic [23:0] gap, input logic [7:0] count,
                             input logic [14:0] amp);
    reg_write(REG_PHASE_INC, inc);
    reg_write(REG_BEEP_SAMP, 32'(beep));
    reg_write(REG_GAP_SAMP, 32'(gap));
    reg_write(REG_BEEP_CNT, 32'(count));
    reg_write(REG_AMPLITUDE, 32'(amp));
  endtask

  // Wait until every slot is sent and every sample is back, then let the
  // pipeline settle before touching registers. Sample at the falling edge,
  // where the driver and monitor updates of the rising edge have settled.
  task automatic wait_drained();
    while (pending_starts.size() != 0 || push || expected_samples.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic queue_slots(input logic starts[$]);
    @(negedge clk);
    foreach (starts[i]) pending_starts.push_back(starts[i]);
    phase_cnt++;
  endtask

  task automatic random_config();
    logic [31:0] inc;
    logic [23:0] beep, gap;
    logic [7:0]  count;
    logic [14:0] amp;
    case ($urandom_range(9, 0))
      0:       inc = 32'd0;
      1:       inc = 32'h8000_0000;
      default: inc = $urandom_range(32'h8000_0000, 0);
    endcase
    case ($urandom_range(9, 0))
      0:       beep = 24'd0;
      1:       beep = 24'($urandom_range(60, 13));
      default: beep = 24'($urandom_range(12, 1));
    endcase
    gap = ($urandom_range(5, 0) == 0) ? 24'd0 : 24'($urandom_range(8, 1));
    case ($urandom_range(11, 0))
      0:       count = 8'd0;
      1:       count = 8'd255;
      default: count = 8'($urandom_range(5, 1));
    endcase
    case ($urandom_range(9, 0))
      0:       amp = 15'd0;
      1:       amp = 15'd32767;
      default: amp = 15'($urandom_range(32767, 0));
    endcase
    load_config(inc, beep, gap, count, amp);
  endtask

  initial begin : stimulus
    logic starts[$];
    int   total, n, restart_odds;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: start, then restart while running
    starts = '{1'b1, 1'b0, 1'b1, 1'b0};
    queue_slots(starts);
    wait_drained();

    // Quarter-wave step at full amplitude: two short beeps with a gap
    load_config(32'h4000_0000, 24'd4, 24'd2, 8'd2, 15'd32767);
    starts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    queue_slots(starts);
    wait_drained();

    // Zero beep count: a start leaves the block idle
    load_config(32'd0, 24'd3, 24'd3, 8'd0, 15'd0);
    starts = '{1'b1, 1'b0};
    queue_slots(starts);
    wait_drained();

    // No slot at all: beeps and gaps both empty
    load_config(32'd0, 24'd0, 24'd0, 8'd255, 15'd100);
    starts = '{1'b1};
    queue_slots(starts);
    wait_drained();

    // Empty beeps: the sequence is only its gaps
    load_config(32'h8000_0000, 24'd0, 24'd3, 8'd2, 15'd32767);
    starts = '{1'b1, 1'b0, 1'b0, 1'b0};
    queue_slots(starts);
    wait_drained();

    // Longest segments; the next phase shrinks them mid-beep
    load_config(32'h8000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 8'd255, 15'd32767);
    starts = '{1'b1, 1'b0};
    queue_slots(starts);
    wait_drained();

    // Random phases: mostly clean sequences with occasional restarts
    total = 0;
    while (total < RANDOM_SLOTS) begin
      random_config();
      n            = (total == 0) ? 200 : $urandom_range(100, 30);
      restart_odds = $urandom_range(128, 16);
      starts       = {};
      for (int i = 0; i < n; i++)
        starts.push_back((i == 0 && $urandom_range(3, 0) != 0) ||
                         $urandom_range(restart_odds - 1, 0) == 0);
      queue_slots(starts);
      total += n;
      wait_drained();
    end

    repeat (3 * PIPE_LATENCY) @(posedge clk);
    $display("Covered %0d slots over %0d phases: %0d tone samples, %0d sequence ends.",
             slots_sent, phase_cnt, tone_seen, ends_seen);
    $display("Input held off by a full block for %0d cycles; %0d mismatches.",
             full_cycles, err_cnt);
    if (err_cnt == 0 && expected_samples.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
